// File: sv/hya_pkg.sv
`default_nettype none
package hya_pkg;

  localparam int FRAME_WIDTH_DEF     = 640;
  localparam int FRAME_HEIGHT_DEF    = 480;
  localparam int COORD_FRAC_BITS_DEF = 6;

  localparam int COEF_W    = 40;
  localparam int COEF_FRAC = 24;
  localparam int NUM_COEFS = 8;
  localparam int IDX_W     = 3;
  localparam int COORD_W   = 16;
  localparam int PROD_W    = COEF_W + COORD_W;
  // sum of two products and a scaled constant term
  localparam int SUM_W     = PROD_W + 2;
  localparam int MAG_W     = SUM_W + 1;
  localparam int DEN_W     = SUM_W - 1;
  // quotient bits kept; anything at or above 2^QBITS is outside any frame
  localparam int QBITS     = 13;
  localparam int CMP_W     = DEN_W + QBITS;
  localparam int PIX_W     = QBITS + 1;
  localparam int COL_W     = 10;
  localparam int ROW_W     = 9;
  localparam int OFS_W     = 20;

  typedef enum logic [IDX_W-1:0] {
    REG_H00 = 3'd0,
    REG_H01 = 3'd1,
    REG_H02 = 3'd2,
    REG_H10 = 3'd3,
    REG_H11 = 3'd4,
    REG_H12 = 3'd5,
    REG_H20 = 3'd6,
    REG_H21 = 3'd7
  } hya_reg_t;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    logic func;
    logic dpos;
  } hya_side_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
  } hya_lane_t;

  typedef struct packed {
    logic [QBITS-1:0] q;
    logic             neg;
    logic             ovf;
  } hya_quot_t;

endpackage
`default_nettype wire

// File: sv/hya_mac.sv
`default_nettype none
module hya_mac import hya_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      ce,
  input  wire logic                      in_valid,
  input  wire logic                      func,
  input  wire logic signed [COORD_W-1:0] view_x,
  input  wire logic signed [COORD_W-1:0] view_y,
  input  wire coef_t                     coef [NUM_COEFS],
  output logic                           out_valid,
  output hya_side_t                      side,
  output logic [DEN_W-1:0]               den,
  output hya_lane_t                      lane_x,
  output hya_lane_t                      lane_y
);

  localparam logic signed [SUM_W-1:0] ONE =
    SUM_W'(1) <<< (COEF_FRAC + COORD_FRAC_BITS);

  // stage 1: products
  logic                     v1_r;
  logic                     f1_r;
  logic signed [PROD_W-1:0] p00_r, p01_r, p10_r, p11_r, p20_r, p21_r;
  logic signed [SUM_W-1:0]  c02_r, c12_r;
  // stage 2: sums
  logic                     v2_r;
  logic                     f2_r;
  logic signed [SUM_W-1:0]  nx_r, ny_r, d_r;
  // stage 3: magnitudes
  logic                     v3_r;
  hya_side_t                side_r;
  logic [DEN_W-1:0]         den_r;
  hya_lane_t                lx_r, ly_r;

  function automatic hya_lane_t mag_of(input logic signed [SUM_W-1:0] n, input logic f);
    logic signed [MAG_W-1:0] w;
    hya_lane_t               l;
    w     = f ? MAG_W'(n) <<< 1 : MAG_W'(n);
    l.neg = w[MAG_W-1];
    l.mag = l.neg ? MAG_W'(-w) : MAG_W'(w);
    return l;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      f1_r  <= func;
      p00_r <= coef[REG_H00] * view_x;
      p01_r <= coef[REG_H01] * view_y;
      p10_r <= coef[REG_H10] * view_x;
      p11_r <= coef[REG_H11] * view_y;
      p20_r <= coef[REG_H20] * view_x;
      p21_r <= coef[REG_H21] * view_y;
      c02_r <= SUM_W'(coef[REG_H02]) <<< COORD_FRAC_BITS;
      c12_r <= SUM_W'(coef[REG_H12]) <<< COORD_FRAC_BITS;

      f2_r <= f1_r;
      nx_r <= SUM_W'(p00_r) + SUM_W'(p01_r) + c02_r;
      ny_r <= SUM_W'(p10_r) + SUM_W'(p11_r) + c12_r;
      d_r  <= SUM_W'(p20_r) + SUM_W'(p21_r) + ONE;

      side_r.func <= f2_r;
      side_r.dpos <= !d_r[SUM_W-1] && (d_r != '0);
      // a non-positive denominator is flagged; divide by one to keep the lanes sane
      den_r <= (!d_r[SUM_W-1] && (d_r != '0)) ? d_r[DEN_W-1:0] : DEN_W'(1);
      lx_r  <= mag_of(nx_r, f2_r);
      ly_r  <= mag_of(ny_r, f2_r);
    end
  end

  assign out_valid = v3_r;
  assign side      = side_r;
  assign den       = den_r;
  assign lane_x    = lx_r;
  assign lane_y    = ly_r;

endmodule
`default_nettype wire

// File: sv/hya_div.sv
`default_nettype none
module hya_div import hya_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             ce,
  input  wire logic             in_valid,
  input  wire hya_side_t        in_side,
  input  wire logic [DEN_W-1:0] den,
  input  wire hya_lane_t        lane_x,
  input  wire hya_lane_t        lane_y,
  output logic                  out_valid,
  output hya_side_t             out_side,
  output hya_quot_t             quot_x,
  output hya_quot_t             quot_y
);

  // restoring divider, one quotient bit per stage, two lanes sharing the divisor
  logic             v_r   [QBITS+1];
  hya_side_t        s_r   [QBITS+1];
  logic [DEN_W-1:0] d_r   [QBITS+1];
  logic [MAG_W-1:0] rem_r [2][QBITS+1];
  logic [QBITS-1:0] q_r   [2][QBITS+1];
  logic             neg_r [2][QBITS+1];
  logic             ovf_r [2][QBITS+1];

  hya_lane_t lane_in [2];
  assign lane_in[0] = lane_x;
  assign lane_in[1] = lane_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QBITS; k++) v_r[k] <= 1'b0;
    end else if (ce) begin
      v_r[0] <= in_valid;
      for (int k = 1; k <= QBITS; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s_r[0] <= in_side;
      d_r[0] <= den;
      for (int k = 1; k <= QBITS; k++) begin
        s_r[k] <= s_r[k-1];
        d_r[k] <= d_r[k-1];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[l][0] <= lane_in[l].mag;
        q_r[l][0]   <= '0;
        neg_r[l][0] <= lane_in[l].neg;
        // quotient would not fit the kept bits
        ovf_r[l][0] <= (CMP_W'(den) << QBITS) <= CMP_W'(lane_in[l].mag);
      end
    end

    for (genvar k = 1; k <= QBITS; k++) begin : g_step
      logic [CMP_W-1:0] trial;
      logic             ge;
      assign trial = CMP_W'(d_r[k-1]) << (QBITS - k);
      assign ge    = CMP_W'(rem_r[l][k-1]) >= trial;
      always_ff @(posedge clk) begin
        if (ce) begin
          rem_r[l][k] <= ge ? rem_r[l][k-1] - trial[MAG_W-1:0] : rem_r[l][k-1];
          q_r[l][k]   <= q_r[l][k-1] | (ge ? QBITS'(1) << (QBITS - k) : '0);
          neg_r[l][k] <= neg_r[l][k-1];
          ovf_r[l][k] <= ovf_r[l][k-1];
        end
      end
    end
  end

  assign out_valid  = v_r[QBITS];
  assign out_side   = s_r[QBITS];
  assign quot_x.q   = q_r[0][QBITS];
  assign quot_x.neg = neg_r[0][QBITS];
  assign quot_x.ovf = ovf_r[0][QBITS];
  assign quot_y.q   = q_r[1][QBITS];
  assign quot_y.neg = neg_r[1][QBITS];
  assign quot_y.ovf = ovf_r[1][QBITS];

endmodule
`default_nettype wire

// File: sv/hya_addr.sv
`default_nettype none
module hya_addr import hya_pkg::*; #(
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      ce,
  input  wire logic      in_valid,
  input  wire hya_side_t side,
  input  wire hya_quot_t quot_x,
  input  wire hya_quot_t quot_y,
  output logic           out_valid,
  output logic           in_range,
  output logic [COL_W-1:0] cam_col,
  output logic [ROW_W-1:0] cam_row,
  output logic [OFS_W-1:0] luma_offset,
  output logic [OFS_W-1:0] cb_offset,
  output logic [OFS_W-1:0] cr_offset
);

  localparam logic [PIX_W:0] WIDTH_C  = (PIX_W+1)'(FRAME_WIDTH);
  localparam logic [PIX_W:0] HEIGHT_C = (PIX_W+1)'(FRAME_HEIGHT);
  localparam int             BASE_W   = 2 * PIX_W + 2;
  localparam logic [BASE_W-1:0] STRIDE = BASE_W'(2 * FRAME_WIDTH);

  logic [PIX_W-1:0] colv, rowv;
  logic             ok;

  logic             va_r, vb_r;
  logic             ok_r;
  logic [PIX_W-1:0] col_r, row_r;

  logic             rng_r;
  logic [COL_W-1:0] col_o_r;
  logic [ROW_W-1:0] row_o_r;
  logic [OFS_W-1:0] luma_r, cb_r, cr_r;
  logic [BASE_W-1:0] base;

  always_comb begin
    colv = side.func ? PIX_W'(quot_x.q) : {quot_x.q, 1'b0};
    rowv = side.func ? PIX_W'(quot_y.q) : {quot_y.q, 1'b0};
    // a negative quotient that truncated to zero still lands on column or row zero
    ok = side.dpos && !quot_x.ovf && !quot_y.ovf
      && (!quot_x.neg || quot_x.q == '0) && (!quot_y.neg || quot_y.q == '0)
      && ((PIX_W+1)'(colv) < WIDTH_C) && ((PIX_W+1)'(rowv) < HEIGHT_C);
  end

  assign base = BASE_W'(row_r) * STRIDE + (BASE_W'(col_r >> 1) << 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (ce) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ok_r  <= ok;
      col_r <= ok ? colv : '0;
      row_r <= ok ? rowv : '0;

      rng_r   <= ok_r;
      col_o_r <= COL_W'(col_r);
      row_o_r <= ROW_W'(row_r);
      luma_r  <= ok_r ? OFS_W'(base + (col_r[0] ? BASE_W'(2) : '0)) : '0;
      cb_r    <= ok_r ? OFS_W'(base + BASE_W'(1)) : '0;
      cr_r    <= ok_r ? OFS_W'(base + BASE_W'(3)) : '0;
    end
  end

  assign out_valid   = vb_r;
  assign in_range    = rng_r;
  assign cam_col     = col_o_r;
  assign cam_row     = row_o_r;
  assign luma_offset = luma_r;
  assign cb_offset   = cb_r;
  assign cr_offset   = cr_r;

endmodule
`default_nettype wire

// File: sv/homography_yuyv_address.sv
// Maps a bird's-eye coordinate through a normalized 3x3 projective transform to a
// camera pixel and its Y, U and V byte offsets in a packed YUYV frame. One coordinate
// is taken every clock cycle while no result waits at the output, where the whole
// pipeline holds. It has 3 multiply/sum stages, 14 stages of the shared-divisor
// restoring divider and 2 address stages. The user must write coefficients through
// the cfg port only while the pipeline is empty; the block itself does not enforce it.
`default_nettype none
module homography_yuyv_address import hya_pkg::*; #(
  parameter int FRAME_WIDTH     = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT    = FRAME_HEIGHT_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [31:0]       in_tdata,   // view_x[15:0], view_y[31:16]
  input  wire logic              in_tuser,   // func
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // cam_col[9:0], cam_row[18:10], luma_offset[38:19], cb_offset[58:39],
  // cr_offset[78:59], zero[79]
  output logic [79:0]            out_tdata,
  output logic                   out_tuser,  // in_range
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [COEF_W-1:0] cfg_data
);

  coef_t coef_r [NUM_COEFS];
  logic  ce;

  logic             mac_v, div_v, addr_v;
  hya_side_t        mac_side, div_side;
  logic [DEN_W-1:0] den;
  hya_lane_t        lane_x, lane_y;
  hya_quot_t        quot_x, quot_y;
  logic             in_range;
  logic [COL_W-1:0] cam_col;
  logic [ROW_W-1:0] cam_row;
  logic [OFS_W-1:0] luma_offset, cb_offset, cr_offset;

  assign ce        = !addr_v || out_tready;
  assign in_tready = ce;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[REG_H00] <= COEF_W'(41391216);
      coef_r[REG_H01] <= COEF_W'(19015616);
      coef_r[REG_H02] <= COEF_W'(-64'sd3658521344);
      coef_r[REG_H10] <= COEF_W'(913187);
      coef_r[REG_H11] <= COEF_W'(48679520);
      coef_r[REG_H12] <= COEF_W'(-381594448);
      coef_r[REG_H20] <= COEF_W'(4727);
      coef_r[REG_H21] <= COEF_W'(127190);
    end else if (cfg_valid) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end

  hya_mac #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_mac (
    .clk, .rst_n, .ce,
    .in_valid (in_tvalid),
    .func     (in_tuser),
    .view_x   (in_tdata[15:0]),
    .view_y   (in_tdata[31:16]),
    .coef     (coef_r),
    .out_valid(mac_v),
    .side     (mac_side),
    .den,
    .lane_x,
    .lane_y
  );

  hya_div u_div (
    .clk, .rst_n, .ce,
    .in_valid (mac_v),
    .in_side  (mac_side),
    .den,
    .lane_x,
    .lane_y,
    .out_valid(div_v),
    .out_side (div_side),
    .quot_x,
    .quot_y
  );

  hya_addr #(.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT)) u_addr (
    .clk, .rst_n, .ce,
    .in_valid (div_v),
    .side     (div_side),
    .quot_x,
    .quot_y,
    .out_valid(addr_v),
    .in_range,
    .cam_col,
    .cam_row,
    .luma_offset,
    .cb_offset,
    .cr_offset
  );

  assign out_tvalid = addr_v;
  assign out_tuser  = in_range;
  assign out_tdata  = {1'b0, cr_offset, cb_offset, luma_offset, cam_row, cam_col};

endmodule
`default_nettype wire
